// ===== src/randomized_set_with_sampling_top_assert.svh =====
// Assertion helpers for the randomized set. They expect clk and arst_n in scope.
`ifndef RANDOMIZED_SET_WITH_SAMPLING_TOP_ASSERT_SVH
`define RANDOMIZED_SET_WITH_SAMPLING_TOP_ASSERT_SVH

`define RSWS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define RSWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rsws_pkg.sv =====
package rsws_pkg;

	localparam int unsigned DATA_W       = 32;
	localparam int unsigned ACT_W        = 2;
	localparam int unsigned DRAW_W       = 15;
	localparam int unsigned ERR_W        = 2;
	localparam int unsigned CAPACITY_DEF = 16;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd2;

	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LAUNCH,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} state_t;

	// Search wave that travels down the row of cells.
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [DATA_W-1:0] last;
		logic [DATA_W-1:0] pick;
	} wave_t;

	typedef struct packed {
		logic              en;
		logic [DATA_W-1:0] data;
	} wr_t;

endpackage

// ===== src/rsws_req_if.sv =====
interface rsws_req_if import rsws_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic signed [DATA_W-1:0] value;
	logic [DRAW_W-1:0]        random_draw;

	modport source (output valid, output action, output value, output random_draw,
		input ready);
	modport sink (input valid, input action, input value, input random_draw,
		output ready);
endinterface

// ===== src/rsws_rsp_if.sv =====
interface rsws_rsp_if import rsws_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     success;
	logic signed [DATA_W-1:0] sampled_value;
	logic [ERR_W-1:0]         error;

	modport source (output valid, output success, output sampled_value, output error,
		input ready);
	modport sink (input valid, input success, input sampled_value, input error,
		output ready);
endinterface

// ===== src/randomized_set_with_sampling_top.sv =====
// Randomized set of distinct 32-bit values with insert, remove and random sampling.
// Members sit densely in a row of CAPACITY cells; a search wave walks the row one cell
// per cycle. An insert or remove that changes the set takes a write step after the walk
// before its result is loaded; one that leaves the set as it is goes straight to the output.
// A sample of a non-empty set first runs the bit-serial draw-mod-count divider ahead of
// the walk. A sample on an empty set and any unused action code skip the walk and go
// straight to the output step. One request is in flight at a time; the next is accepted
// in the cycle after the result is loaded, while that result still waits in the output
// register, and a request stalls before loading its result as long as the previous
// result has not been taken.
`include "randomized_set_with_sampling_top_assert.svh"

module randomized_set_with_sampling_top import rsws_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rsws_req_if.sink   req,
	rsws_rsp_if.source rsp
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [ACT_W-1:0]  act_q, act_d;
	logic [DATA_W-1:0] val_q, val_d;
	logic [IW-1:0]     sel_q, sel_d;
	wr_t               wr_q, wr_d;
	logic [IW-1:0]     wr_idx_q, wr_idx_d;
	logic              res_success_q, res_success_d;
	logic [DATA_W-1:0] res_sampled_q, res_sampled_d;
	logic [ERR_W-1:0]  res_error_q, res_error_d;
	logic              rsp_valid_q, rsp_valid_d;
	logic              rsp_success_q, rsp_success_d;
	logic [DATA_W-1:0] rsp_sampled_q, rsp_sampled_d;
	logic [ERR_W-1:0]  rsp_error_q, rsp_error_d;
	logic              req_ready;
	logic              mod_start;
	logic              mod_done;
	logic [CW-1:0]     mod_rem;
	wr_t               wr_bus;
	wave_t             chain [CAPACITY+1];
	logic [IW-1:0]     slot_chain [CAPACITY+1];
	wave_t             tail;

	rsws_mod #(
		.CAPACITY(CAPACITY)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(req.random_draw),
		.divisor (cnt_q),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	always_comb begin
		chain[0]       = '0;
		chain[0].valid = (state_q == ST_LAUNCH);
		slot_chain[0]  = '0;
	end

	assign wr_bus.en   = (state_q == ST_WRITE) && wr_q.en;
	assign wr_bus.data = wr_q.data;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rsws_cell #(
			.CAPACITY(CAPACITY),
			.IDX     (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev_wave(chain[i]),
			.prev_slot(slot_chain[i]),
			.next_wave(chain[i+1]),
			.next_slot(slot_chain[i+1]),
			.value    (val_q),
			.count    (cnt_q),
			.sel      (sel_q),
			.wr       (wr_bus),
			.wr_idx   (wr_idx_q)
		);
	end

	assign tail = chain[CAPACITY];

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		act_d         = act_q;
		val_d         = val_q;
		sel_d         = sel_q;
		wr_d          = wr_q;
		wr_idx_d      = wr_idx_q;
		res_success_d = res_success_q;
		res_sampled_d = res_sampled_q;
		res_error_d   = res_error_q;
		rsp_valid_d   = rsp_valid_q;
		rsp_success_d = rsp_success_q;
		rsp_sampled_d = rsp_sampled_q;
		rsp_error_d   = rsp_error_q;
		req_ready     = 1'b0;
		mod_start     = 1'b0;
		if (rsp_valid_q && rsp.ready) begin
			rsp_valid_d = 1'b0;
		end
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					act_d         = req.action;
					val_d         = req.value;
					wr_d.en       = 1'b0;
					res_success_d = 1'b0;
					res_sampled_d = '0;
					res_error_d   = ERR_NONE;
					if ((req.action == ACT_INSERT) || (req.action == ACT_REMOVE)) begin
						sel_d   = '0;
						state_d = ST_LAUNCH;
					end else if (req.action == ACT_SAMPLE) begin
						if (cnt_q == '0) begin
							res_error_d = ERR_EMPTY;
							state_d     = ST_OUT;
						end else begin
							mod_start = 1'b1;
							state_d   = ST_DIV;
						end
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_DIV: begin
				if (mod_done) begin
					sel_d   = mod_rem[IW-1:0];
					state_d = ST_LAUNCH;
				end
			end
			ST_LAUNCH: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (tail.valid) begin
					state_d = ST_OUT;
					case (act_q)
						ACT_INSERT: begin
							if (!tail.found) begin
								if (cnt_q == CW'(CAPACITY)) begin
									res_error_d = ERR_FULL;
								end else begin
									wr_d.en       = 1'b1;
									wr_d.data     = val_q;
									wr_idx_d      = cnt_q[IW-1:0];
									res_success_d = 1'b1;
									state_d       = ST_WRITE;
								end
							end
						end
						ACT_REMOVE: begin
							if (tail.found) begin
								wr_d.en       = 1'b1;
								wr_d.data     = tail.last;
								wr_idx_d      = slot_chain[CAPACITY];
								res_success_d = 1'b1;
								state_d       = ST_WRITE;
							end
						end
						ACT_SAMPLE: begin
							res_sampled_d = tail.pick;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WRITE: begin
				if (act_q == ACT_INSERT) begin
					cnt_d = cnt_q + CW'(1);
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_valid_d   = 1'b1;
					rsp_success_d = res_success_q;
					rsp_sampled_d = res_sampled_q;
					rsp_error_d   = res_error_q;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			wr_q        <= '0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rsp_valid_q <= rsp_valid_d;
			wr_q        <= wr_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q         <= act_d;
		val_q         <= val_d;
		sel_q         <= sel_d;
		wr_idx_q      <= wr_idx_d;
		res_success_q <= res_success_d;
		res_sampled_q <= res_sampled_d;
		res_error_q   <= res_error_d;
		rsp_success_q <= rsp_success_d;
		rsp_sampled_q <= rsp_sampled_d;
		rsp_error_q   <= rsp_error_d;
	end

	assign req.ready         = req_ready;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.success       = rsp_success_q;
	assign rsp.sampled_value = rsp_sampled_q;
	assign rsp.error         = rsp_error_q;

	`RSWS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY),
		"Member count exceeds capacity.")
	`RSWS_ASSERT_NEXT(a_cnt_hold, state_q != ST_WRITE, $stable(cnt_q),
		"Member count changed outside the write step.")
	`RSWS_ASSERT_SAME(a_wave_scan, tail.valid, state_q == ST_SCAN,
		"Search wave left the row outside a scan.")
	`RSWS_ASSERT_SAME(a_rsp_excl, rsp_valid_q, !(rsp_success_q && (rsp_error_q != ERR_NONE)),
		"Result reports success together with an error.")

endmodule

// ===== src/rsws_cell.sv =====
module rsws_cell import rsws_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	parameter int unsigned IDX      = 0,
	localparam int unsigned CW = $clog2(CAPACITY + 1),
	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wave_t             prev_wave,
	input  logic [IW-1:0]     prev_slot,
	output wave_t             next_wave,
	output logic [IW-1:0]     next_slot,
	input  logic [DATA_W-1:0] value,
	input  logic [CW-1:0]     count,
	input  logic [IW-1:0]     sel,
	input  wr_t               wr,
	input  logic [IW-1:0]     wr_idx
);

	logic [DATA_W-1:0] entry_q;
	wave_t             wave_q;
	logic [IW-1:0]     slot_q;
	wave_t             wave_d;
	logic [IW-1:0]     slot_d;
	logic              hit;

	always_ff @(posedge clk) begin
		if (wr.en && (wr_idx == IW'(IDX))) begin
			entry_q <= wr.data;
		end
	end

	assign hit = (CW'(IDX) < count) && (entry_q == value);

	always_comb begin
		wave_d = prev_wave;
		slot_d = prev_slot;
		if (hit) begin
			wave_d.found = 1'b1;
			slot_d       = IW'(IDX);
		end
		if (CW'(IDX + 1) == count) begin
			wave_d.last = entry_q;
		end
		if (sel == IW'(IDX)) begin
			wave_d.pick = entry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
			slot_q <= '0;
		end else begin
			wave_q <= wave_d;
			slot_q <= slot_d;
		end
	end

	assign next_wave = wave_q;
	assign next_slot = slot_q;

endmodule

// ===== src/rsws_mod.sv =====
module rsws_mod import rsws_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DRAW_W-1:0] dividend,
	input  logic [CW-1:0]     divisor,
	output logic              done,
	output logic [CW-1:0]     rem
);

	localparam int unsigned SW = $clog2(DRAW_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [SW-1:0]     step_q;
	logic [DRAW_W-1:0] dvd_q;
	logic [CW-1:0]     rem_q;
	logic [CW:0]       trial;
	logic [CW:0]       diff;
	logic [CW-1:0]     rem_n;

	// One quotient bit per cycle, restoring form.
	always_comb begin
		trial = {rem_q, dvd_q[DRAW_W-1]};
		diff  = trial - {1'b0, divisor};
		if (trial >= {1'b0, divisor}) begin
			rem_n = diff[CW-1:0];
		end else begin
			rem_n = trial[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= SW'(DRAW_W);
			dvd_q  <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_n;
			dvd_q  <= {dvd_q[DRAW_W-2:0], 1'b0};
			step_q <= step_q - SW'(1);
			if (step_q == SW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
